/* rtl/ucd_pkg.sv */
// Shared types and constants for the UTF-8 codepoint decoder pipeline.
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW       = 21'h00D800;
    localparam logic [20:0] SURR_HIGH      = 21'h00DFFF;
    localparam logic [20:0] FLOOR_TWO      = 21'h000080;
    localparam logic [20:0] FLOOR_THREE    = 21'h000800;
    localparam logic [20:0] FLOOR_FOUR     = 21'h010000;
    localparam logic [7:0]  ASCII_LIMIT    = 8'h80;
    localparam logic [7:0]  LEAD_MIN       = 8'hC2;
    localparam logic [7:0]  LEAD_THREE     = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR      = 8'hF0;
    localparam logic [7:0]  LEAD_LIMIT     = 8'hF8;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_TAG       = 8'h80;
    localparam logic [2:0]  MAX_WINDOW     = 3'd4;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_ASCII,
        KIND_BAD,
        KIND_MULTI
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  seq_len;
        logic [2:0]  avail;
        logic [7:0]  lead;
        logic [3:1]  cont;
        logic [5:0]  pay1;
        logic [5:0]  pay2;
        logic [5:0]  pay3;
    } s1_t;

    typedef struct packed {
        kind_t       kind;
        logic        complete;
        logic [2:0]  brk;
        logic [2:0]  seq_len;
        logic [20:0] cp;
    } s2_t;

endpackage

`default_nettype wire

/* rtl/ucd_classify.sv */
// Stage one: lead byte class, sequence length and continuation flags.
`timescale 1ns / 1ps
`default_nettype none

module ucd_classify (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    output logic             up_stall,
    input  wire logic [7:0]  lead_byte,
    input  wire logic [7:0]  second_byte,
    input  wire logic [7:0]  third_byte,
    input  wire logic [7:0]  fourth_byte,
    input  wire logic [2:0]  available_bytes,
    output logic             dn_valid,
    output ucd_pkg::s1_t     dn_data,
    input  wire logic        dn_stall
);

    logic         v_reg;
    logic         v_next;
    logic         load;
    ucd_pkg::s1_t d_reg;
    ucd_pkg::s1_t d_next;

    assign up_stall = v_reg && dn_stall;
    assign load     = !up_stall;
    assign v_next   = up_valid;

    always_comb
    begin
        d_next.avail = (available_bytes > ucd_pkg::MAX_WINDOW) ? ucd_pkg::MAX_WINDOW
                                                               : available_bytes;
        d_next.lead  = lead_byte;
        d_next.pay1  = second_byte[5:0];
        d_next.pay2  = third_byte[5:0];
        d_next.pay3  = fourth_byte[5:0];
        d_next.cont[1] = (second_byte & ucd_pkg::CONT_MASK) == ucd_pkg::CONT_TAG;
        d_next.cont[2] = (third_byte & ucd_pkg::CONT_MASK) == ucd_pkg::CONT_TAG;
        d_next.cont[3] = (fourth_byte & ucd_pkg::CONT_MASK) == ucd_pkg::CONT_TAG;

        if (d_next.avail == 3'd0)
            d_next.kind = ucd_pkg::KIND_EMPTY;
        else if (lead_byte < ucd_pkg::ASCII_LIMIT)
            d_next.kind = ucd_pkg::KIND_ASCII;
        else if (lead_byte < ucd_pkg::LEAD_MIN || lead_byte >= ucd_pkg::LEAD_LIMIT)
            d_next.kind = ucd_pkg::KIND_BAD;
        else
            d_next.kind = ucd_pkg::KIND_MULTI;

        if (lead_byte < ucd_pkg::LEAD_THREE)
            d_next.seq_len = 3'd2;
        else if (lead_byte < ucd_pkg::LEAD_FOUR)
            d_next.seq_len = 3'd3;
        else
            d_next.seq_len = 3'd4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (load)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

`default_nettype wire

/* rtl/ucd_assemble.sv */
// Stage two: break position of the sequence and codepoint assembly.
`timescale 1ns / 1ps
`default_nettype none

module ucd_assemble (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    input  ucd_pkg::s1_t     up_data,
    output logic             up_stall,
    output logic             dn_valid,
    output ucd_pkg::s2_t     dn_data,
    input  wire logic        dn_stall
);

    logic         v_reg;
    logic         load;
    logic         ok1;
    logic         ok2;
    logic         ok3;
    ucd_pkg::s2_t d_reg;
    ucd_pkg::s2_t d_next;

    assign up_stall = v_reg && dn_stall;
    assign load     = !up_stall;

    assign ok1 = (up_data.avail > 3'd1) && up_data.cont[1];
    assign ok2 = (up_data.avail > 3'd2) && up_data.cont[2];
    assign ok3 = (up_data.avail > 3'd3) && up_data.cont[3];

    always_comb
    begin
        d_next.kind     = up_data.kind;
        d_next.seq_len  = up_data.seq_len;
        d_next.complete = 1'b0;
        d_next.brk      = 3'd1;
        d_next.cp       = {13'd0, up_data.lead};

        // first missing or non-continuation byte
        if (!ok1)
            d_next.brk = 3'd1;
        else if (up_data.seq_len > 3'd2 && !ok2)
            d_next.brk = 3'd2;
        else if (up_data.seq_len > 3'd3 && !ok3)
            d_next.brk = 3'd3;
        else
            d_next.complete = 1'b1;

        if (up_data.kind == ucd_pkg::KIND_MULTI)
        begin
            unique case (up_data.seq_len)
                3'd2:    d_next.cp = {10'd0, up_data.lead[4:0], up_data.pay1};
                3'd3:    d_next.cp = {5'd0, up_data.lead[3:0], up_data.pay1, up_data.pay2};
                default: d_next.cp = {up_data.lead[2:0], up_data.pay1, up_data.pay2,
                                      up_data.pay3};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (load)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

`default_nettype wire

/* rtl/ucd_check.sv */
// Stage three: overlong, surrogate and range checks, result register.
`timescale 1ns / 1ps
`default_nettype none

module ucd_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    input  ucd_pkg::s2_t     up_data,
    output logic             up_stall,
    output logic             dn_valid,
    output logic [20:0]      codepoint,
    output logic [2:0]       consumed,
    input  wire logic        dn_stall
);

    logic        v_reg;
    logic        load;
    logic        bad_val;
    logic [20:0] floor_cp;
    logic [20:0] cp_reg;
    logic [20:0] cp_next;
    logic [2:0]  used_reg;
    logic [2:0]  used_next;

    assign up_stall = v_reg && dn_stall;
    assign load     = !up_stall;

    always_comb
    begin
        unique case (up_data.seq_len)
            3'd2:    floor_cp = ucd_pkg::FLOOR_TWO;
            3'd3:    floor_cp = ucd_pkg::FLOOR_THREE;
            default: floor_cp = ucd_pkg::FLOOR_FOUR;
        endcase

        bad_val = (up_data.cp < floor_cp)
               || (up_data.cp >= ucd_pkg::SURR_LOW && up_data.cp <= ucd_pkg::SURR_HIGH)
               || (up_data.cp > ucd_pkg::MAX_SCALAR);

        unique case (up_data.kind)
            ucd_pkg::KIND_EMPTY:
            begin
                cp_next   = ucd_pkg::REPLACEMENT_CP;
                used_next = 3'd0;
            end
            ucd_pkg::KIND_ASCII:
            begin
                cp_next   = up_data.cp;
                used_next = 3'd1;
            end
            ucd_pkg::KIND_BAD:
            begin
                cp_next   = ucd_pkg::REPLACEMENT_CP;
                used_next = 3'd1;
            end
            default:
            begin
                if (!up_data.complete)
                begin
                    cp_next   = ucd_pkg::REPLACEMENT_CP;
                    used_next = up_data.brk;
                end
                else if (bad_val)
                begin
                    cp_next   = ucd_pkg::REPLACEMENT_CP;
                    used_next = 3'd1;
                end
                else
                begin
                    cp_next   = up_data.cp;
                    used_next = up_data.seq_len;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (load)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            cp_reg   <= cp_next;
            used_reg <= used_next;
        end
    end

    assign dn_valid  = v_reg;
    assign codepoint = cp_reg;
    assign consumed  = used_reg;

endmodule

`default_nettype wire

/* rtl/utf8_codepoint_decoder.sv */
// A window passes through the classify, assemble and check stage registers in that order.
// Throughput: one window per cycle while out_stall is low; each stage register reloads whenever it is empty
// or the stage after it moves on, so bubbles close up under stall.
// Reset (rst_n low, asynchronous) clears the three stage valid bits; payload is not reset.
// No state is kept between windows.
`timescale 1ns / 1ps
`default_nettype none

module utf8_codepoint_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  lead_byte,
    input  wire logic [7:0]  second_byte,
    input  wire logic [7:0]  third_byte,
    input  wire logic [7:0]  fourth_byte,
    input  wire logic [2:0]  available_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [20:0]      codepoint,
    output logic [2:0]       consumed
);

    logic          s1_valid;
    logic          s1_stall;
    ucd_pkg::s1_t  s1_data;
    logic          s2_valid;
    logic          s2_stall;
    ucd_pkg::s2_t  s2_data;

    ucd_classify u_classify (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (in_valid),
        .up_stall        (in_stall),
        .lead_byte       (lead_byte),
        .second_byte     (second_byte),
        .third_byte      (third_byte),
        .fourth_byte     (fourth_byte),
        .available_bytes (available_bytes),
        .dn_valid        (s1_valid),
        .dn_data         (s1_data),
        .dn_stall        (s1_stall)
    );

    ucd_assemble u_assemble (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_data  (s1_data),
        .up_stall (s1_stall),
        .dn_valid (s2_valid),
        .dn_data  (s2_data),
        .dn_stall (s2_stall)
    );

    ucd_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s2_valid),
        .up_data   (s2_data),
        .up_stall  (s2_stall),
        .dn_valid  (out_valid),
        .codepoint (codepoint),
        .consumed  (consumed),
        .dn_stall  (out_stall)
    );

    // back-pressure only ever comes from a full pipe
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s1_valid && s2_valid))
        else $error("input stalled without a full pipe");

    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && consumed == 3'd0) |-> (codepoint == ucd_pkg::REPLACEMENT_CP))
        else $error("zero consumed without replacement");

    a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (codepoint <= ucd_pkg::MAX_SCALAR && consumed <= ucd_pkg::MAX_WINDOW))
        else $error("result out of range");

    a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(codepoint >= ucd_pkg::SURR_LOW && codepoint <= ucd_pkg::SURR_HIGH))
        else $error("surrogate emitted");

    a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && available_bytes != 3'd0 && !lead_byte[7])
        ##1 !s1_stall ##1 !s2_stall
        |=> (out_valid && consumed == 3'd1 && codepoint == {13'd0, $past(lead_byte, 3)}))
        else $error("ASCII byte not passed through");

endmodule

`default_nettype wire
